FILE: design/i2cms_pkg.sv
// Package for the I2C master transfer sequencer: transaction payload types,
// function and bus status codes, and the decode control struct.
// No dependencies.
package i2cms_pkg;

  // function codes of an input transaction
  localparam logic [1:0] FUNC_LOAD   = 2'd0;
  localparam logic [1:0] FUNC_START  = 2'd1;
  localparam logic [1:0] FUNC_STATUS = 2'd2;
  localparam logic [1:0] FUNC_READ   = 2'd3;

  // bus engine status codes
  localparam logic [7:0] ST_START      = 8'h08;
  localparam logic [7:0] ST_RESTART    = 8'h10;
  localparam logic [7:0] ST_ADDR_W_ACK = 8'h18;
  localparam logic [7:0] ST_DATA_ACK   = 8'h28;
  localparam logic [7:0] ST_ARB_LOST   = 8'h38;
  localparam logic [7:0] ST_ADDR_R_ACK = 8'h40;
  localparam logic [7:0] ST_RX_ACK     = 8'h50;
  localparam logic [7:0] ST_RX_NACK    = 8'h58;

  // configuration register indexes
  localparam logic CFG_TARGET_ADDRESS  = 1'b0;
  localparam logic CFG_TRANSFER_LENGTH = 1'b1;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] status_code;
    logic [7:0] rx_byte;
    logic [4:0] buf_index;
    logic [7:0] buf_value;
  } in_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_load;
    logic       start_set;
    logic       start_clear;
    logic       stop_set;
    logic       ack_set;
    logic       ack_clear;
    logic       done_res;
    logic       success;
    logic [7:0] read_byte;
  } out_t;

  // decode result carried from accept to the buffer read stage
  typedef struct packed {
    logic       mem_we;     // write the buffer this cycle
    logic       addr_idx;   // buffer address from buf_index, else from position
    logic       tx_mem;     // tx_byte comes from buffer read data
    logic       rd_mem;     // read_byte comes from buffer read data
    logic [7:0] tx_byte;    // tx_byte when not from the buffer
    logic       tx_load;
    logic       start_set;
    logic       start_clear;
    logic       stop_set;
    logic       ack_set;
    logic       ack_clear;
    logic       done_res;
    logic       success;
  } ctl_t;

endpackage

FILE: design/i2cms_decode.sv
// Status and command decode for the I2C master transfer sequencer.
// Works out the next position and flags plus the per-transaction control.
// Depends on i2cms_pkg.
module i2cms_decode #(
  parameter int BUFFER_DEPTH = 32,
  parameter int PW           = 6
) (
  input  i2cms_pkg::in_t  cmd,
  input  logic [7:0]      target_address,
  input  logic [5:0]      transfer_length,
  input  logic [PW-1:0]   pos,
  input  logic            done_flag,
  input  logic            good_flag,
  output logic [PW-1:0]   pos_next,
  output logic            done_next,
  output logic            good_next,
  output i2cms_pkg::ctl_t ctl
);

  logic [8:0]    pos9;
  logic [8:0]    pos_inc9;
  logic [8:0]    len9;
  logic [8:0]    depth9;
  logic          pos_ok;
  logic          idx_ok;
  logic [PW-1:0] pos_inc;
  logic          finish;
  logic          ok;

  // range checks against the buffer depth, position saturates at the depth
  assign depth9  = 9'(BUFFER_DEPTH);
  assign pos9    = 9'(pos);
  assign len9    = 9'(transfer_length);
  assign pos_ok  = pos9 < depth9;
  assign idx_ok  = 9'(cmd.buf_index) < depth9;
  assign pos_inc = pos_ok ? PW'(pos9 + 9'd1) : pos;
  assign pos_inc9 = 9'(pos_inc);

  // decode of one transaction
  always_comb begin
    ctl       = '0;
    pos_next  = pos;
    done_next = done_flag;
    good_next = good_flag;
    finish    = 1'b0;
    ok        = 1'b0;
    unique case (cmd.func)
      i2cms_pkg::FUNC_LOAD: begin
        ctl.mem_we   = idx_ok;
        ctl.addr_idx = 1'b1;
      end
      i2cms_pkg::FUNC_START: begin
        pos_next      = '0;
        done_next     = 1'b0;
        good_next     = 1'b0;
        ctl.start_set = 1'b1;
      end
      i2cms_pkg::FUNC_READ: begin
        ctl.addr_idx = 1'b1;
        ctl.rd_mem   = idx_ok;
      end
      default: begin
        unique case (cmd.status_code)
          i2cms_pkg::ST_START: begin
            ctl.tx_byte     = target_address;
            ctl.tx_load     = 1'b1;
            ctl.start_clear = 1'b1;
            finish          = pos9 >= len9;
          end
          i2cms_pkg::ST_RESTART: begin
            pos_next        = '0;
            ctl.tx_byte     = target_address;
            ctl.tx_load     = 1'b1;
            ctl.start_clear = 1'b1;
          end
          i2cms_pkg::ST_ADDR_W_ACK: begin
            ctl.tx_load = 1'b1;
            ctl.tx_mem  = pos_ok;
            pos_next    = pos_inc;
          end
          i2cms_pkg::ST_DATA_ACK: begin
            if (pos9 == len9) begin
              finish = 1'b1;
              ok     = 1'b1;
            end else begin
              ctl.tx_load = 1'b1;
              ctl.tx_mem  = pos_ok;
              pos_next    = pos_inc;
            end
          end
          i2cms_pkg::ST_ARB_LOST: begin
            ctl.start_set = 1'b1;
          end
          i2cms_pkg::ST_ADDR_R_ACK: begin
            ctl.ack_set = 1'b1;
          end
          i2cms_pkg::ST_RX_ACK: begin
            ctl.mem_we = pos_ok;
            pos_next   = pos_inc;
            if (pos_inc9 == len9) begin
              ctl.ack_clear = 1'b1;
            end else begin
              ctl.ack_set = 1'b1;
            end
          end
          i2cms_pkg::ST_RX_NACK: begin
            finish = 1'b1;
            ok     = 1'b1;
          end
          default: begin
            finish = 1'b1;
          end
        endcase
        // end of transfer: stop and flag
        if (finish) begin
          ctl.stop_set = 1'b1;
          done_next    = 1'b1;
          if (ok) begin
            good_next = 1'b1;
          end
        end
      end
    endcase
    ctl.done_res = done_next;
    ctl.success  = good_next;
  end

endmodule

FILE: design/i2c_master_transfer_sequencer_unit.sv
// Top level of the I2C master transfer sequencer: config registers, byte
// buffer memory, position and flags, and the two-stage result pipeline.
// Depends on i2cms_pkg and i2cms_decode.
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+------------------------------
//  in      | input     | in_valid/in_stall | in_data (i2cms_pkg::in_t)
//  out     | output    | out_valid/out_stall | out_data (i2cms_pkg::out_t)
//  cfg     | input     | cfg_we            | cfg_index, cfg_data
//
// One transaction per cycle while in_stall is low; each result is registered in
// the read stage (synchronous buffer read) and then in the output register.
// Position and flags are updated at accept, so the next transaction sees them.
// rst (synchronous) clears position, flags, config and pipeline valids; the
// buffer has no reset. in_stall rises only when both the read stage and the
// output register hold results and out_stall is high.
module i2c_master_transfer_sequencer_unit #(
  parameter int BUFFER_DEPTH = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  i2cms_pkg::in_t  in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output i2cms_pkg::out_t out_data,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [7:0]      cfg_data
);

  localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int PW = $clog2(BUFFER_DEPTH + 1);

  logic [7:0]      target_address;
  logic [5:0]      transfer_length;
  logic [PW-1:0]   pos;
  logic [PW-1:0]   pos_next;
  logic            done_flag;
  logic            done_next;
  logic            good_flag;
  logic            good_next;
  i2cms_pkg::ctl_t ctl;
  i2cms_pkg::ctl_t s1_ctl;
  logic            s1_valid;
  logic [7:0]      rd_data;
  logic [7:0]      mem [BUFFER_DEPTH];
  logic [AW-1:0]   mem_addr;
  logic [7:0]      mem_wdata;
  logic [8:0]      idx9;
  logic [8:0]      pos9;
  logic            accept;
  logic            out_free;
  logic            s1_move;
  i2cms_pkg::out_t s1_result;

  // handshake
  assign out_free = !out_valid || !out_stall;
  assign s1_move  = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;
  assign accept   = in_valid && !in_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      target_address  <= '0;
      transfer_length <= '0;
    end else if (cfg_we) begin
      if (cfg_index == i2cms_pkg::CFG_TARGET_ADDRESS) begin
        target_address <= cfg_data;
      end else begin
        transfer_length <= cfg_data[5:0];
      end
    end
  end

  i2cms_decode #(
    .BUFFER_DEPTH(BUFFER_DEPTH),
    .PW          (PW)
  ) u_decode (
    .cmd            (in_data),
    .target_address (target_address),
    .transfer_length(transfer_length),
    .pos            (pos),
    .done_flag      (done_flag),
    .good_flag      (good_flag),
    .pos_next       (pos_next),
    .done_next      (done_next),
    .good_next      (good_next),
    .ctl            (ctl)
  );

  // position and transfer flags
  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      done_flag <= 1'b0;
      good_flag <= 1'b0;
    end else if (accept) begin
      pos       <= pos_next;
      done_flag <= done_next;
      good_flag <= good_next;
    end
  end

  // buffer address and write data, one port shared by read and write
  assign idx9      = 9'(in_data.buf_index);
  assign pos9      = 9'(pos);
  assign mem_addr  = ctl.addr_idx ? idx9[AW-1:0] : pos9[AW-1:0];
  assign mem_wdata = (in_data.func == i2cms_pkg::FUNC_LOAD) ? in_data.buf_value
                                                            : in_data.rx_byte;

  // byte buffer, read data registered at accept
  always_ff @(posedge clk) begin
    if (accept) begin
      if (ctl.mem_we) begin
        mem[mem_addr] <= mem_wdata;
      end
      rd_data <= mem[mem_addr];
    end
  end

  // read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ctl <= ctl;
    end
  end

  // merge buffer data into the result
  always_comb begin
    s1_result.tx_byte     = s1_ctl.tx_mem ? rd_data : s1_ctl.tx_byte;
    s1_result.tx_load     = s1_ctl.tx_load;
    s1_result.start_set   = s1_ctl.start_set;
    s1_result.start_clear = s1_ctl.start_clear;
    s1_result.stop_set    = s1_ctl.stop_set;
    s1_result.ack_set     = s1_ctl.ack_set;
    s1_result.ack_clear   = s1_ctl.ack_clear;
    s1_result.done_res    = s1_ctl.done_res;
    s1_result.success     = s1_ctl.success;
    s1_result.read_byte   = s1_ctl.rd_mem ? rd_data : 8'd0;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_data <= s1_result;
    end
  end

  // checks
  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    accept && in_data.func == i2cms_pkg::FUNC_START |=> pos == '0 && !done_flag && !good_flag)
    else $error("start transaction did not clear position and flags");

  a_pos_saturates: assert property (@(posedge clk) disable iff (rst)
    9'(pos) <= 9'(BUFFER_DEPTH))
    else $error("position ran past the buffer depth");

  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_free |=> s1_valid && $stable(s1_ctl) && $stable(rd_data))
    else $error("read stage lost or changed a waiting result");

  a_no_tx_noise: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_ctl.tx_load |-> s1_result.tx_byte == 8'd0)
    else $error("tx_byte nonzero without tx_load");

endmodule
